FILE: hw/rtl/banked_ram_expansion_port_assert.svh
// Assertion macros for the checker file of the expansion port.
`ifndef BANKED_RAM_EXPANSION_PORT_ASSERT_SVH
`define BANKED_RAM_EXPANSION_PORT_ASSERT_SVH

// Check prop at every rising edge of clk, suspended while rst is high.
`define BREP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("expansion port check failed");

// Check prop at every rising edge of clk, reset cycles included.
`define BREP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("expansion port check failed");

`endif

FILE: hw/rtl/brep_pkg.sv
// Shared types and constants of the banked RAM expansion port.
`timescale 1ns / 1ps
package brep_pkg;

  localparam int RegCount  = 16;
  localparam int RegIdxW   = 4;
  localparam int ByteW     = 8;
  localparam int MemDepth  = 131072;
  localparam int MemAddrW  = 17;

  // Register offsets within the file
  localparam logic [RegIdxW-1:0] OFF_PORT_B  = 4'h0;
  localparam logic [RegIdxW-1:0] OFF_PORT_A  = 4'h1;
  localparam logic [RegIdxW-1:0] OFF_DIR_B   = 4'h2;
  localparam logic [RegIdxW-1:0] OFF_DIR_A   = 4'h3;
  localparam logic [RegIdxW-1:0] OFF_CONTROL = 4'hc;

  // Control bits that select the bank
  localparam logic [ByteW-1:0] CTRL_BANK_HI = 8'h0e;
  localparam logic [ByteW-1:0] CTRL_BANK_LO = 8'he0;

  typedef enum logic [1:0] {
    MODE_REG_RD = 2'd0,
    MODE_REG_WR = 2'd1,
    MODE_RAM_RD = 2'd2,
    MODE_RAM_WR = 2'd3
  } mode_t;

  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] index;
    logic [ByteW-1:0]   data;
  } reg_wr_t;

endpackage

FILE: hw/rtl/brep_ram.sv
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module brep_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: hw/rtl/brep_regs.sv
// Register file, bank select and RAM address generation.
`timescale 1ns / 1ps
module brep_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  brep_pkg::reg_wr_t                    wr,
  input  logic [brep_pkg::RegIdxW-1:0]         rd_index,
  output logic [brep_pkg::ByteW-1:0]           rd_data,
  output logic [brep_pkg::MemAddrW-1:0]        ram_addr
);

  logic [brep_pkg::ByteW-1:0] regs [brep_pkg::RegCount];
  logic [1:0]                 bank;
  logic [1:0]                 bank_next;
  logic [brep_pkg::ByteW-1:0] ctrl_next;
  logic [brep_pkg::ByteW-1:0] eff_a;
  logic [brep_pkg::ByteW-1:0] eff_b;

  // Bank follows the control value as it stands after this write
  always_comb begin
    ctrl_next = (wr.index == brep_pkg::OFF_CONTROL) ? wr.data
                                                    : regs[brep_pkg::OFF_CONTROL];
    bank_next = {(ctrl_next & brep_pkg::CTRL_BANK_HI) == brep_pkg::CTRL_BANK_HI,
                 (ctrl_next & brep_pkg::CTRL_BANK_LO) == brep_pkg::CTRL_BANK_LO};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < brep_pkg::RegCount; i++) begin
        regs[i] <= '0;
      end
      bank <= 2'b00;
    end else if (wr.en) begin
      regs[wr.index] <= wr.data;
      bank           <= bank_next;
    end
  end

  // Input pins (direction bit clear) read as high
  always_comb begin
    eff_a = (regs[brep_pkg::OFF_PORT_A] & regs[brep_pkg::OFF_DIR_A])
            | ~regs[brep_pkg::OFF_DIR_A];
    eff_b = (regs[brep_pkg::OFF_PORT_B] & regs[brep_pkg::OFF_DIR_B])
            | ~regs[brep_pkg::OFF_DIR_B];
  end

  assign rd_data  = regs[rd_index];
  assign ram_addr = {bank, eff_b[6:0], eff_a};

endmodule

FILE: hw/rtl/banked_ram_expansion_port.sv
// Top level of the banked RAM expansion port: stream front end, clear sweep, RAM.
// A read transaction shows its byte on the output in the cycle after acceptance.
// Throughput: one transaction per cycle while the RAM is not being cleared; reads wait
//   for the single output register to drain. Writes pass a held result.
// Reset: registers and bank clear at once; the RAM is then zeroed one byte a cycle,
//   from address 0 up to the last, during which no transaction is accepted.
`timescale 1ns / 1ps
module banked_ram_expansion_port (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [3:0] reg_index, [11:4] write_data, [15:12] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [7:0] read_data
);

  localparam logic [brep_pkg::MemAddrW-1:0] ClrLast =
    brep_pkg::MemAddrW'(brep_pkg::MemDepth - 1);

  // Input fields
  brep_pkg::mode_t                  mode;
  logic [brep_pkg::RegIdxW-1:0]     reg_index;
  logic [brep_pkg::ByteW-1:0]       write_data;

  // Decoded transaction
  logic accept;
  logic is_reg_rd;
  logic is_reg_wr;
  logic is_ram_rd;
  logic is_ram_wr;

  // Clear sweep
  logic                             clearing;
  logic [brep_pkg::MemAddrW-1:0]    clr_addr;

  // Output register
  logic                             out_valid;
  logic                             out_valid_next;
  logic                             out_from_ram;
  logic [brep_pkg::ByteW-1:0]       out_reg;

  // Register file and RAM connections
  brep_pkg::reg_wr_t                reg_wr;
  logic [brep_pkg::ByteW-1:0]       reg_rd_data;
  logic [brep_pkg::MemAddrW-1:0]    ram_addr;
  logic                             mem_en;
  logic                             mem_we;
  logic [brep_pkg::MemAddrW-1:0]    mem_addr;
  logic [brep_pkg::ByteW-1:0]       mem_wdata;
  logic [brep_pkg::ByteW-1:0]       mem_rdata;

  assign mode       = brep_pkg::mode_t'(s_axis_tuser);
  assign reg_index  = s_axis_tdata[3:0];
  assign write_data = s_axis_tdata[11:4];

  always_comb begin
    is_reg_rd = 1'b0;
    is_reg_wr = 1'b0;
    is_ram_rd = 1'b0;
    is_ram_wr = 1'b0;
    unique case (mode)
      brep_pkg::MODE_REG_RD: begin
        is_reg_rd = 1'b1;
      end
      brep_pkg::MODE_REG_WR: begin
        is_reg_wr = 1'b1;
      end
      brep_pkg::MODE_RAM_RD: begin
        is_ram_rd = 1'b1;
      end
      brep_pkg::MODE_RAM_WR: begin
        is_ram_wr = 1'b1;
      end
      default: begin
        is_reg_rd = 1'b0;
      end
    endcase
  end

  // Writes make no result, so they need no room in the output register
  assign s_axis_tready = !rst && !clearing &&
                         (!out_valid || m_axis_tready || is_reg_wr || is_ram_wr);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Sweep the RAM to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + brep_pkg::MemAddrW'(1);
      if (clr_addr == ClrLast) begin
        clearing <= 1'b0;
      end
    end
  end

  assign reg_wr.en    = accept && is_reg_wr;
  assign reg_wr.index = reg_index;
  assign reg_wr.data  = write_data;

  brep_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr       (reg_wr),
    .rd_index (reg_index),
    .rd_data  (reg_rd_data),
    .ram_addr (ram_addr)
  );

  // The sweep owns the RAM port until it ends
  assign mem_en    = clearing || (accept && (is_ram_rd || is_ram_wr));
  assign mem_we    = clearing || is_ram_wr;
  assign mem_addr  = clearing ? clr_addr : ram_addr;
  assign mem_wdata = clearing ? '0 : write_data;

  brep_ram #(
    .Width (brep_pkg::ByteW),
    .Depth (brep_pkg::MemDepth)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Hold a result until it is taken; a read accepted now replaces it
  always_comb begin
    out_valid_next = out_valid;
    if (accept && (is_reg_rd || is_ram_rd)) begin
      out_valid_next = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      out_from_ram <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (accept && (is_reg_rd || is_ram_rd)) begin
        out_from_ram <= is_ram_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_reg_rd) begin
      out_reg <= reg_rd_data;
    end
  end

  // RAM read data stays put until the next RAM read, so it serves as the held byte
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_from_ram ? mem_rdata : out_reg;

endmodule

FILE: hw/rtl/brep_checker.sv
// Port-level checks of the banked RAM expansion port, bound to the top level.
`timescale 1ns / 1ps
`include "banked_ram_expansion_port_assert.svh"
module brep_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [1:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  logic in_fire;
  logic out_stall;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // No stale result and no transaction straight after reset (sweep running)
  `BREP_ASSERT_ALWAYS(a_idle_after_rst, clk, rst |=> !m_axis_tvalid && !s_axis_tready)

  // A stalled result holds its byte
  `BREP_ASSERT(a_out_hold, clk, rst, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata))

  // Every accepted read (mode bit 0 clear) delivers a result in the next cycle
  `BREP_ASSERT(a_read_result, clk, rst, in_fire && !s_axis_tuser[0] |=> m_axis_tvalid)

  // A write never invents a result
  `BREP_ASSERT(a_write_silent, clk, rst, !m_axis_tvalid && in_fire && s_axis_tuser[0] |=> !m_axis_tvalid)

endmodule

bind banked_ram_expansion_port brep_checker u_brep_checker (.*);

FILE: test/banked_ram_expansion_port_test.sv
// Stream-level test of the banked RAM expansion port against a cycle-free predictor.
`timescale 1ns / 1ps
module banked_ram_expansion_port_test;

  // Watchdog bound: the RAM clear after reset plus a slow run, several times over
  localparam int CycleLimit = 1_000_000;
  localparam int RandomAccesses = 1200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [3:0] reg_index, [11:4] write_data, [15:12] zero
  logic [1:0]  s_axis_tuser = '0;   // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] read_data

  // Shadow copy of the block state, zero as after the reset clear
  bit [brep_pkg::ByteW-1:0] shadow_regs [brep_pkg::RegCount];
  bit [1:0]                 shadow_bank;
  bit [brep_pkg::ByteW-1:0] shadow_ram [brep_pkg::MemDepth];

  // Bytes that read transactions must return, oldest first
  logic [brep_pkg::ByteW-1:0] pending_reads [$];

  int error_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int stall_span = 0;
  int stall_style = 0;

  banked_ram_expansion_port uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Port pins marked as inputs by the direction register read back high
  function automatic logic [brep_pkg::ByteW-1:0] port_level(
    logic [brep_pkg::ByteW-1:0] data, logic [brep_pkg::ByteW-1:0] dir);
    return (data & dir) | ~dir;
  endfunction

  function automatic logic [brep_pkg::MemAddrW-1:0] ram_location();
    logic [brep_pkg::ByteW-1:0] pb;
    logic [brep_pkg::ByteW-1:0] pa;
    pb = port_level(shadow_regs[brep_pkg::OFF_PORT_B], shadow_regs[brep_pkg::OFF_DIR_B]);
    pa = port_level(shadow_regs[brep_pkg::OFF_PORT_A], shadow_regs[brep_pkg::OFF_DIR_A]);
    return {shadow_bank, pb[6:0], pa};
  endfunction

  // Advance the shadow state by one accepted transaction; queue the byte a read returns
  task automatic predict_bus_access(brep_pkg::mode_t mode,
                                    logic [brep_pkg::RegIdxW-1:0] idx,
                                    logic [brep_pkg::ByteW-1:0] data);
    logic [brep_pkg::ByteW-1:0] ctrl;
    case (mode)
      brep_pkg::MODE_REG_RD: begin
        pending_reads.push_back(shadow_regs[idx]);
      end
      brep_pkg::MODE_REG_WR: begin
        shadow_regs[idx] = data;
        ctrl = shadow_regs[brep_pkg::OFF_CONTROL];
        // Any register write re-derives the bank from the control byte
        shadow_bank = {(ctrl & brep_pkg::CTRL_BANK_HI) == brep_pkg::CTRL_BANK_HI,
                       (ctrl & brep_pkg::CTRL_BANK_LO) == brep_pkg::CTRL_BANK_LO};
      end
      brep_pkg::MODE_RAM_RD: begin
        pending_reads.push_back(shadow_ram[ram_location()]);
      end
      default: begin
        shadow_ram[ram_location()] = data;
      end
    endcase
  endtask

  // Drop valid and let the clock run on before the next offer
  task automatic hold_off(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Offer one transaction, paced in bursts, and hold it until accepted.
  // Valid stays high afterwards so that a following transaction can go back to back.
  task automatic send_access(brep_pkg::mode_t mode, logic [brep_pkg::RegIdxW-1:0] idx,
                             logic [brep_pkg::ByteW-1:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      // Some bursts follow on with no gap at all
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) hold_off(gap);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'h0, data, idx};
    s_axis_tuser  <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_bus_access(mode, idx, data);
  endtask

  // Pause the sender until every outstanding read has come back
  task automatic drain_reads();
    hold_off(1);
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  task automatic flag_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Receiver: switch between stall styles after a span of random length
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_span  <= $urandom_range(16, 96);
      stall_style <= $urandom_range(0, 3);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_style)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (stall_span[1:0] != 2'b11);
    endcase
  end

  // Check every result transaction against the oldest expected byte
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_reads.size() == 0) begin
        flag_mismatch($sformatf("unexpected read_data 0x%02h", m_axis_tdata));
      end else begin
        if (m_axis_tdata !== pending_reads[0])
          flag_mismatch($sformatf("read_data 0x%02h, expected 0x%02h",
                                  m_axis_tdata, pending_reads[0]));
        void'(pending_reads.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("banked_ram_expansion_port_test: done, errors");
      $finish;
    end
  end

  // Registers and RAM must read as zero once the clear sweep is over
  task automatic test_reset_values();
    send_access(brep_pkg::MODE_REG_RD, brep_pkg::OFF_PORT_B, 8'hff);
    send_access(brep_pkg::MODE_REG_RD, 4'hf, 8'h00);
    // Direction zero: every port pin is an input, so the address is 0x07fff
    send_access(brep_pkg::MODE_RAM_RD, 4'h5, 8'hff);
  endtask

  // Extremes, every mode, bank combinations, direction forcing, ignored fields
  task automatic test_directed_accesses();
    send_access(brep_pkg::MODE_RAM_WR, 4'hf, 8'hff);
    send_access(brep_pkg::MODE_RAM_RD, 4'h0, 8'h00);
    // All pins outputs, ports zero: address 0
    send_access(brep_pkg::MODE_REG_WR, brep_pkg::OFF_DIR_B, 8'hff);
    send_access(brep_pkg::MODE_REG_WR, brep_pkg::OFF_DIR_A, 8'hff);
    send_access(brep_pkg::MODE_RAM_WR, 4'h0, 8'ha5);
    send_access(brep_pkg::MODE_RAM_RD, 4'hf, 8'hff);
    // Port B bit 7 falls outside the address
    send_access(brep_pkg::MODE_REG_WR, brep_pkg::OFF_PORT_B, 8'hff);
    send_access(brep_pkg::MODE_REG_WR, brep_pkg::OFF_PORT_A, 8'hff);
    send_access(brep_pkg::MODE_RAM_RD, 4'h3, 8'h00);
    // Upper bank bit alone, then lower alone, then both
    send_access(brep_pkg::MODE_REG_WR, brep_pkg::OFF_CONTROL, 8'h0e);
    send_access(brep_pkg::MODE_RAM_RD, 4'h0, 8'h00);
    send_access(brep_pkg::MODE_RAM_WR, 4'h0, 8'h3c);
    send_access(brep_pkg::MODE_REG_WR, brep_pkg::OFF_CONTROL, 8'he0);
    send_access(brep_pkg::MODE_RAM_WR, 4'h0, 8'h81);
    send_access(brep_pkg::MODE_REG_WR, brep_pkg::OFF_CONTROL, 8'hff);
    send_access(brep_pkg::MODE_RAM_WR, 4'h0, 8'h01);
    // A write to a plain storage byte leaves the bank alone
    send_access(brep_pkg::MODE_REG_WR, 4'hf, 8'hff);
    send_access(brep_pkg::MODE_RAM_RD, 4'h0, 8'h00);
    send_access(brep_pkg::MODE_REG_RD, brep_pkg::OFF_CONTROL, 8'h00);
    // Control bits 3:1 not all set: back to bank zero
    send_access(brep_pkg::MODE_REG_WR, brep_pkg::OFF_CONTROL, 8'h0c);
    send_access(brep_pkg::MODE_RAM_RD, 4'h0, 8'h00);
    // Low nibble of port A as outputs, high nibble forced high
    send_access(brep_pkg::MODE_REG_WR, brep_pkg::OFF_DIR_A, 8'h0f);
    send_access(brep_pkg::MODE_REG_WR, brep_pkg::OFF_PORT_A, 8'h35);
    send_access(brep_pkg::MODE_RAM_RD, 4'h0, 8'h00);
  endtask

  // Hold the sender twice until all reads are back, with traffic either side
  task automatic test_drain_pause();
    send_access(brep_pkg::MODE_RAM_RD, 4'h0, 8'h00);
    send_access(brep_pkg::MODE_REG_RD, brep_pkg::OFF_DIR_A, 8'h00);
    drain_reads();
    send_access(brep_pkg::MODE_RAM_WR, 4'h9, 8'h5a);
    send_access(brep_pkg::MODE_RAM_RD, 4'h9, 8'h00);
    drain_reads();
  endtask

  function automatic logic [brep_pkg::ByteW-1:0] pick_port_byte();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range(0, 3));
      1: return 8'hff ^ 8'($urandom_range(0, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [brep_pkg::ByteW-1:0] pick_dir_byte();
    case ($urandom_range(0, 4))
      0: return 8'hff;
      1: return 8'h00;
      2: return 8'h0f;
      3: return 8'hf0;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [brep_pkg::ByteW-1:0] pick_control_byte();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'h0e;
      2: return 8'he0;
      3: return 8'hee;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mixed traffic; port and control bytes come mostly from small pools so that
  // RAM addresses recur and reads land on bytes written earlier
  task automatic test_random_traffic();
    int pick;
    logic [brep_pkg::RegIdxW-1:0] idx;
    logic [brep_pkg::ByteW-1:0] data;
    for (int n = 0; n < RandomAccesses; n++) begin
      pick = $urandom_range(0, 99);
      idx  = 4'($urandom_range(0, 15));
      data = 8'($urandom_range(0, 255));
      if (pick < 25) begin
        case ($urandom_range(0, 5))
          0: idx = brep_pkg::OFF_PORT_B;
          1: idx = brep_pkg::OFF_PORT_A;
          2: idx = brep_pkg::OFF_DIR_B;
          3: idx = brep_pkg::OFF_DIR_A;
          4: idx = brep_pkg::OFF_CONTROL;
          default: ;
        endcase
        if (idx == brep_pkg::OFF_PORT_B || idx == brep_pkg::OFF_PORT_A)
          data = pick_port_byte();
        else if (idx == brep_pkg::OFF_DIR_B || idx == brep_pkg::OFF_DIR_A)
          data = pick_dir_byte();
        else if (idx == brep_pkg::OFF_CONTROL)
          data = pick_control_byte();
        send_access(brep_pkg::MODE_REG_WR, idx, data);
      end else if (pick < 35) begin
        send_access(brep_pkg::MODE_REG_RD, idx, data);
      end else if (pick < 65) begin
        send_access(brep_pkg::MODE_RAM_WR, idx, data);
      end else begin
        send_access(brep_pkg::MODE_RAM_RD, idx, data);
      end
      if ($urandom_range(0, 199) == 0) drain_reads();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed_accesses();
    test_drain_pause();
    test_random_traffic();
    hold_off(0);
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("banked_ram_expansion_port_test: done, clean");
    end else begin
      $display("banked_ram_expansion_port_test: done, errors");
    end
    $finish;
  end

endmodule
